// ===== hw/rtl/asbl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asbl_pkg: shared types and constants of the setpoint biquad limiter
// Field widths, command and clamp codes, register indexes, the history
// word layout, the accumulator control group and the per-axis limit table.
// ----------------------------------------------------------------------------
package asbl_pkg;

  localparam int DATA_W    = 32;
  localparam int AXIS_W    = 3;
  localparam int CLAMP_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 2 * DATA_W;
  // Five Q18.46 terms plus the rounding bias fit in 66 bits; one spare bit.
  localparam int ACC_W     = PROD_W + 3;
  localparam int FRAC_SHIFT = 30;

  localparam logic CMD_INIT = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [CLAMP_W-1:0] CLAMP_NONE = 2'd0;
  localparam logic [CLAMP_W-1:0] CLAMP_LOW  = 2'd1;
  localparam logic [CLAMP_W-1:0] CLAMP_HIGH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  // One history entry per axis, all four words read and written together.
  typedef struct packed {
    logic signed [DATA_W-1:0] oh2;
    logic signed [DATA_W-1:0] oh1;
    logic signed [DATA_W-1:0] ih2;
    logic signed [DATA_W-1:0] ih1;
  } hist_t;

  typedef struct packed {
    logic clear;
    logic acc_en;
    logic sub;
  } mac_ctrl_t;

  // Operating limits in Q16.16 degrees.
  function automatic logic signed [DATA_W-1:0] lim_lo(input logic [AXIS_W-1:0] ax);
    logic signed [DATA_W-1:0] r;
    case (ax)
      3'd0:    r = 32'(-170 * 65536);
      3'd1:    r = 32'(-85 * 65536);
      3'd2:    r = 32'(-170 * 65536);
      3'd3:    r = 32'(-210 * 65536);
      3'd4:    r = 32'(-130 * 65536);
      3'd5:    r = 32'(-2700 * 65536);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] lim_hi(input logic [AXIS_W-1:0] ax);
    logic signed [DATA_W-1:0] r;
    case (ax)
      3'd0:    r = 32'(170 * 65536);
      3'd1:    r = 32'(175 * 65536);
      3'd2:    r = '0;
      3'd3:    r = 32'(210 * 65536);
      3'd4:    r = 32'(130 * 65536);
      3'd5:    r = 32'(2700 * 65536);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/asbl_hist_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asbl_hist_mem: per-axis filter history memory
// One read and one write port, registered read data. Entries never written
// since reset read as zero through a valid bit per entry.
// ----------------------------------------------------------------------------
module asbl_hist_mem
  import asbl_pkg::*;
#(
  parameter int DEPTH = 6,
  parameter int AW    = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output hist_t         rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  hist_t         wr_data
);

  hist_t            mem [DEPTH];
  hist_t            rd_word;
  logic             rd_valid;
  logic [DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_word : '0;

endmodule

// ===== hw/rtl/asbl_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asbl_mac: shared multiply-accumulate unit of the biquad
// One registered 32x32 signed product per cycle, an exact accumulator that
// starts at the rounding bias, and the rounded, saturated filter output.
// ----------------------------------------------------------------------------
module asbl_mac
  import asbl_pkg::*;
(
  input  logic                     clk,
  input  mac_ctrl_t                ctrl,
  input  logic signed [DATA_W-1:0] op_a,
  input  logic signed [DATA_W-1:0] op_b,
  output logic signed [DATA_W-1:0] y
);

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'sd1 <<< (FRAC_SHIFT - 1));
  localparam int SHIFT_W = ACC_W - FRAC_SHIFT;

  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   sum;
  logic signed [SHIFT_W-1:0] shifted;

  assign prod_ext = ACC_W'(prod);
  assign sum      = ctrl.sub ? (acc - prod_ext) : (acc + prod_ext);
  assign shifted  = sum[ACC_W-1:FRAC_SHIFT];

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (ctrl.clear) begin
      acc <= ROUND_BIAS;
    end else if (ctrl.acc_en) begin
      acc <= sum;
    end
  end

  // Saturate the floored Q16.16 value to the signed 32-bit range.
  always_comb begin
    if (shifted > SHIFT_W'(64'sh7FFF_FFFF)) begin
      y = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (shifted < -SHIFT_W'(64'sh8000_0000)) begin
      y = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      y = shifted[DATA_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/axis_setpoint_biquad_limiter.sv =====
`timescale 1ns / 1ps
// Filter step: the memory read, then the five products on one shared 32x32 multiplier,
// then the finishing step; the next item loads in that step once the output can take it.
// Init and out-of-range axis items skip the read and the products and only finish.
// Synchronous reset clears the coefficients, the handshakes and the history valid bits,
// so all history reads as zero until an axis is written; no clearing pass is needed.
// ----------------------------------------------------------------------------
// axis_setpoint_biquad_limiter: per-axis setpoint clamp, biquad and limiter
// Clamps a joint setpoint to its operating limits, adds the calibration
// offset, runs a direct-form-I biquad over the per-axis history and
// clamps the filter output again; init items preload the history instead.
// ----------------------------------------------------------------------------
module axis_setpoint_biquad_limiter
  import asbl_pkg::*;
#(
  parameter int AXIS_COUNT = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  // Input items
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      command,
  input  logic [AXIS_W-1:0]         axis,
  input  logic signed [DATA_W-1:0]  value_deg,
  input  logic signed [DATA_W-1:0]  offset_deg,
  // Result items
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [AXIS_W-1:0]         axis_out,
  output logic signed [DATA_W-1:0]  position_deg,
  output logic [CLAMP_W-1:0]        setpoint_clamp,
  output logic [CLAMP_W-1:0]        output_clamp,
  // Coefficient writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [DATA_W-1:0]         cfg_data
);

  localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

  // Engine sequence: one product per step, then the finishing step that
  // rounds, writes the history back and hands the result to the output.
  localparam logic [2:0] STEP_B0  = 3'd0;
  localparam logic [2:0] STEP_B1  = 3'd1;
  localparam logic [2:0] STEP_B2  = 3'd2;
  localparam logic [2:0] STEP_A1  = 3'd3;
  localparam logic [2:0] STEP_A2  = 3'd4;
  localparam logic [2:0] STEP_FIN = 3'd5;

  // Coefficient registers, Q2.30.
  logic signed [DATA_W-1:0] coef_b0;
  logic signed [DATA_W-1:0] coef_b1;
  logic signed [DATA_W-1:0] coef_b2;
  logic signed [DATA_W-1:0] coef_a1;
  logic signed [DATA_W-1:0] coef_a2;

  // Input buffer. It takes the next transfer while the engine works.
  logic                     buf_valid;
  logic                     buf_cmd;
  logic [AXIS_W-1:0]        buf_axis;
  logic signed [DATA_W-1:0] buf_value;
  logic signed [DATA_W-1:0] buf_offset;

  // Engine registers for the item in flight.
  logic                     busy;
  logic [2:0]               step;
  logic [AXIS_W-1:0]        cur_axis;
  logic                     cur_init;
  logic                     cur_oor;
  logic signed [DATA_W-1:0] cur_x;
  logic [CLAMP_W-1:0]       cur_sc;
  hist_t                    hist;

  // Forwarding of a history write that coincides with the next read.
  logic                     fwd_hit;
  hist_t                    fwd_word;

  // Load side, worked out on the buffered item.
  logic signed [DATA_W-1:0] buf_lo;
  logic signed [DATA_W-1:0] buf_hi;
  logic signed [DATA_W-1:0] sp_clamped;
  logic [CLAMP_W-1:0]       sp_code;
  logic signed [DATA_W:0]   sp_sum;
  logic signed [DATA_W-1:0] x_calc;
  logic                     buf_oor;
  logic                     buf_quick;

  // Finish side.
  logic signed [DATA_W-1:0] cur_lo;
  logic signed [DATA_W-1:0] cur_hi;
  logic signed [DATA_W-1:0] y;
  logic signed [DATA_W-1:0] pos;
  logic [CLAMP_W-1:0]       oc;

  logic                     fin_go;
  logic                     load;
  logic                     rd_en;
  logic                     wr_en;
  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            wr_addr;
  hist_t                    rd_data;
  hist_t                    wr_data;

  mac_ctrl_t                mac_ctrl;
  logic signed [DATA_W-1:0] op_a;
  logic signed [DATA_W-1:0] op_b;

  // --------------------------------------------------------------------------
  // Configuration. Writes are taken in any cycle; unknown indexes are dropped.
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= '0;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_B0:  coef_b0 <= cfg_data;
        REG_B1:  coef_b1 <= cfg_data;
        REG_B2:  coef_b2 <= cfg_data;
        REG_A1:  coef_a1 <= cfg_data;
        REG_A2:  coef_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and sequencing.
  // --------------------------------------------------------------------------
  assign in_ready = !buf_valid;

  // The finishing step completes only when the output register is free or
  // is emptied in the same cycle. The next item is loaded in that same cycle,
  // so the memory read of one item overlaps the write-back of the previous.
  assign fin_go = busy && (step == STEP_FIN) && (!out_valid || out_ready);
  assign load   = buf_valid && (!busy || fin_go);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      buf_cmd    <= command;
      buf_axis   <= axis;
      buf_value  <= value_deg;
      buf_offset <= offset_deg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      buf_valid <= 1'b1;
    end else if (load) begin
      buf_valid <= 1'b0;
    end
  end

  // Setpoint clamp and offset add with saturation, done as the item loads.
  always_comb begin
    buf_lo  = lim_lo(buf_axis);
    buf_hi  = lim_hi(buf_axis);
    buf_oor = {1'b0, buf_axis} >= (AXIS_W + 1)'(AXIS_COUNT);
    buf_quick = buf_oor || (buf_cmd == CMD_INIT);
    if (buf_value < buf_lo) begin
      sp_clamped = buf_lo;
      sp_code    = CLAMP_LOW;
    end else if (buf_value > buf_hi) begin
      sp_clamped = buf_hi;
      sp_code    = CLAMP_HIGH;
    end else begin
      sp_clamped = buf_value;
      sp_code    = CLAMP_NONE;
    end
    sp_sum = {sp_clamped[DATA_W-1], sp_clamped} + {buf_offset[DATA_W-1], buf_offset};
    if (sp_sum[DATA_W] != sp_sum[DATA_W-1]) begin
      x_calc = sp_sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      x_calc = sp_sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_B0;
    end else if (load) begin
      busy <= 1'b1;
      // Init and out-of-range items need no products and go straight to
      // the finishing step.
      step <= buf_quick ? STEP_FIN : STEP_B0;
    end else if (fin_go) begin
      busy <= 1'b0;
    end else if (busy && (step != STEP_FIN)) begin
      step <= step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_axis <= buf_axis;
      cur_init <= (buf_cmd == CMD_INIT);
      cur_oor  <= buf_oor;
      cur_x    <= (buf_cmd == CMD_INIT) ? buf_value : x_calc;
      cur_sc   <= sp_code;
      fwd_hit  <= wr_en && (wr_addr == rd_addr);
      fwd_word <= wr_data;
    end
    // The history arrives in the cycle after the read; a write to the same
    // axis in the load cycle is taken from the forwarding register instead.
    if (busy && (step == STEP_B0)) begin
      hist <= fwd_hit ? fwd_word : rd_data;
    end
  end

  // --------------------------------------------------------------------------
  // History memory.
  // --------------------------------------------------------------------------
  assign rd_en   = load && !buf_quick;
  assign rd_addr = buf_axis[AW-1:0];
  assign wr_en   = fin_go && !cur_oor;
  assign wr_addr = cur_axis[AW-1:0];

  always_comb begin
    if (cur_init) begin
      wr_data = '{oh2: cur_x, oh1: cur_x, ih2: cur_x, ih1: cur_x};
    end else begin
      wr_data = '{oh2: hist.oh1, oh1: y, ih2: hist.ih1, ih1: cur_x};
    end
  end

  asbl_hist_mem #(
    .DEPTH (AXIS_COUNT),
    .AW    (AW)
  ) u_hist_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // --------------------------------------------------------------------------
  // Shared multiplier. Each step multiplies one tap; the accumulator adds
  // the product of the step before, subtracting the two feedback terms.
  // --------------------------------------------------------------------------
  always_comb begin
    case (step)
      STEP_B0: begin
        op_a = cur_x;
        op_b = coef_b0;
      end
      STEP_B1: begin
        op_a = hist.ih1;
        op_b = coef_b1;
      end
      STEP_B2: begin
        op_a = hist.ih2;
        op_b = coef_b2;
      end
      STEP_A1: begin
        op_a = hist.oh1;
        op_b = coef_a1;
      end
      default: begin
        op_a = hist.oh2;
        op_b = coef_a2;
      end
    endcase
    mac_ctrl.clear  = busy && (step == STEP_B0);
    mac_ctrl.acc_en = busy && (step inside {[STEP_B1:STEP_A2]});
    mac_ctrl.sub    = (step == STEP_A2) || (step == STEP_FIN);
  end

  asbl_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (op_a),
    .op_b (op_b),
    .y    (y)
  );

  // --------------------------------------------------------------------------
  // Output clamp and result register. The unclamped value y is what the
  // history keeps; only the result is limited.
  // --------------------------------------------------------------------------
  always_comb begin
    cur_lo = lim_lo(cur_axis);
    cur_hi = lim_hi(cur_axis);
    if (y < cur_lo) begin
      pos = cur_lo;
      oc  = CLAMP_LOW;
    end else if (y > cur_hi) begin
      pos = cur_hi;
      oc  = CLAMP_HIGH;
    end else begin
      pos = y;
      oc  = CLAMP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      axis_out <= cur_axis;
      if (cur_oor) begin
        position_deg   <= '0;
        setpoint_clamp <= CLAMP_NONE;
        output_clamp   <= CLAMP_NONE;
      end else if (cur_init) begin
        position_deg   <= cur_x;
        setpoint_clamp <= CLAMP_NONE;
        output_clamp   <= CLAMP_NONE;
      end else begin
        position_deg   <= pos;
        setpoint_clamp <= cur_sc;
        output_clamp   <= oc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== dv/axis_setpoint_biquad_limiter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_setpoint_biquad_limiter_test: self-checking bench of the joint filter
// Drives init and filter-step items through the setpoint clamp, biquad and
// output limiter under several coefficient sets, with random idle bursts on
// both channels, and checks every result against a cycle-free model kept in
// a small scoreboard class.
// ----------------------------------------------------------------------------
import asbl_pkg::*;

class position_ledger #(int JOINTS = 6);

  typedef struct {
    logic [AXIS_W-1:0]        ax;
    logic signed [DATA_W-1:0] pos;
    logic [CLAMP_W-1:0]       sc;
    logic [CLAMP_W-1:0]       oc;
  } joint_result_t;

  logic signed [DATA_W-1:0] b0, b1, b2, a1, a2;
  logic signed [DATA_W-1:0] x_one[JOINTS], x_two[JOINTS];
  logic signed [DATA_W-1:0] y_one[JOINTS], y_two[JOINTS];
  logic signed [DATA_W-1:0] floor_lim[JOINTS], ceil_lim[JOINTS];
  joint_result_t            awaited[$];
  int                       errors;

  function new();
    int lo_deg[6];
    int hi_deg[6];
    lo_deg = '{-170, -85, -170, -210, -130, -2700};
    hi_deg = '{170, 175, 0, 210, 130, 2700};
    b0 = '0; b1 = '0; b2 = '0; a1 = '0; a2 = '0;
    errors = 0;
    for (int i = 0; i < JOINTS; i++) begin
      floor_lim[i] = lo_deg[i] * 65536;
      ceil_lim[i]  = hi_deg[i] * 65536;
      x_one[i] = '0; x_two[i] = '0; y_one[i] = '0; y_two[i] = '0;
    end
  endfunction

  function logic signed [DATA_W-1:0] saturate(logic signed [69:0] v);
    if (v > 70'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -70'sd2147483648) return 32'sh80000000;
    return v[DATA_W-1:0];
  endfunction

  function logic signed [69:0] product(logic signed [DATA_W-1:0] p,
                                       logic signed [DATA_W-1:0] q);
    logic signed [69:0] wp;
    logic signed [69:0] wq;
    wp = p;
    wq = q;
    return wp * wq;
  endfunction

  function void set_coef(logic [CFG_IDX_W-1:0] idx, logic signed [DATA_W-1:0] data);
    case (idx)
      REG_B0: b0 = data;
      REG_B1: b1 = data;
      REG_B2: b2 = data;
      REG_A1: a1 = data;
      REG_A2: a2 = data;
      default: ;
    endcase
  endfunction

  function void note_item(logic cmd, logic [AXIS_W-1:0] ax,
                          logic signed [DATA_W-1:0] val,
                          logic signed [DATA_W-1:0] off);
    joint_result_t            r;
    logic signed [DATA_W-1:0] target;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [69:0]       wide;
    r.ax  = ax;
    r.pos = '0;
    r.sc  = CLAMP_NONE;
    r.oc  = CLAMP_NONE;
    if (ax < JOINTS) begin
      if (cmd == CMD_INIT) begin
        x_one[ax] = val; x_two[ax] = val; y_one[ax] = val; y_two[ax] = val;
        r.pos = val;
      end else begin
        target = val;
        if (target < floor_lim[ax]) begin
          target = floor_lim[ax];
          r.sc = CLAMP_LOW;
        end
        if (target > ceil_lim[ax]) begin
          target = ceil_lim[ax];
          r.sc = CLAMP_HIGH;
        end
        wide = target;
        wide = wide + off;
        x = saturate(wide);
        wide = product(x, b0) + product(x_one[ax], b1) + product(x_two[ax], b2)
             - product(y_one[ax], a1) - product(y_two[ax], a2);
        // Round half up from Q18.46 down to Q16.16.
        wide = (wide + 70'sd536870912) >>> 30;
        y = saturate(wide);
        x_two[ax] = x_one[ax];
        x_one[ax] = x;
        y_two[ax] = y_one[ax];
        y_one[ax] = y;
        r.pos = y;
        if (r.pos < floor_lim[ax]) begin
          r.pos = floor_lim[ax];
          r.oc = CLAMP_LOW;
        end
        if (r.pos > ceil_lim[ax]) begin
          r.pos = ceil_lim[ax];
          r.oc = CLAMP_HIGH;
        end
      end
    end
    awaited.push_back(r);
  endfunction

  function void check_result(logic [AXIS_W-1:0] ax, logic signed [DATA_W-1:0] pos,
                             logic [CLAMP_W-1:0] sc, logic [CLAMP_W-1:0] oc);
    joint_result_t e;
    if (awaited.size() == 0) begin
      $error("result for axis %0d arrived with no item outstanding", ax);
      errors++;
      return;
    end
    e = awaited.pop_front();
    if (ax !== e.ax) begin
      $error("axis_out: expected %0d, actual %0d", e.ax, ax);
      errors++;
    end
    if (pos !== e.pos) begin
      $error("position_deg: expected %0d, actual %0d", e.pos, pos);
      errors++;
    end
    if (sc !== e.sc) begin
      $error("setpoint_clamp: expected %0d, actual %0d", e.sc, sc);
      errors++;
    end
    if (oc !== e.oc) begin
      $error("output_clamp: expected %0d, actual %0d", e.oc, oc);
      errors++;
    end
  endfunction

  function int outstanding();
    return awaited.size();
  endfunction

endclass

module axis_setpoint_biquad_limiter_test;

  localparam int JOINTS          = 6;
  localparam int ITEMS_PER_PHASE = 275;
  // The slowest legal run needs far less than this; the limit leaves ample room.
  localparam int CYCLE_LIMIT     = 600000;
  // Idle wait after the last result, before the final check.
  localparam int TAIL_CYCLES     = 20;
  localparam int Q16             = 65536;

  localparam logic signed [DATA_W-1:0] S32_TOP    = 32'sh7FFFFFFF;
  localparam logic signed [DATA_W-1:0] S32_BOTTOM = 32'sh80000000;
  // Q2.30 coefficient values.
  localparam logic signed [DATA_W-1:0] Q30_ONE     = 32'sd1073741824;
  localparam logic signed [DATA_W-1:0] Q30_QUARTER = 32'sd268435456;
  localparam logic signed [DATA_W-1:0] Q30_ZERO    = 32'sd0;
  localparam logic signed [DATA_W-1:0] LP_B0       = 32'sd72477573;
  localparam logic signed [DATA_W-1:0] LP_B1       = 32'sd144955146;
  localparam logic signed [DATA_W-1:0] LP_A1       = -32'sd1227286905;
  localparam logic signed [DATA_W-1:0] LP_A2       = 32'sd443240625;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     command = CMD_INIT;
  logic [AXIS_W-1:0]        axis = '0;
  logic signed [DATA_W-1:0] value_deg = '0;
  logic signed [DATA_W-1:0] offset_deg = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b1;
  logic [AXIS_W-1:0]        axis_out;
  logic signed [DATA_W-1:0] position_deg;
  logic [CLAMP_W-1:0]       setpoint_clamp;
  logic [CLAMP_W-1:0]       output_clamp;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data = '0;

  // Cleared for the last phase so that it runs with both channels flowing freely.
  bit                       idling = 1'b1;
  int                       cycles;
  position_ledger #(JOINTS) ledger;

  axis_setpoint_biquad_limiter #(
    .AXIS_COUNT(JOINTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .axis(axis),
    .value_deg(value_deg),
    .offset_deg(offset_deg),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .axis_out(axis_out),
    .position_deg(position_deg),
    .setpoint_clamp(setpoint_clamp),
    .output_clamp(output_clamp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Every result transfer is checked at the edge where it happens. Signals read
  // here still hold their values from just before the edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      ledger.check_result(axis_out, position_deg, setpoint_clamp, output_clamp);
    end
  end

  // The result side stalls in random bursts between runs of ready while idling is set.
  initial begin
    @(posedge clk);
    forever begin
      if (idling && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  // Presents one item and returns at the edge of its transfer. Valid stays high
  // afterwards, so back-to-back items never drop it; an idle burst lowers it
  // first. The item goes to the scoreboard only once the transfer has happened.
  task automatic send_item(input logic cmd, input logic [AXIS_W-1:0] ax,
                           input logic signed [DATA_W-1:0] val,
                           input logic signed [DATA_W-1:0] off);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    axis       <= ax;
    value_deg  <= val;
    offset_deg <= off;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ledger.note_item(cmd, ax, val, off);
  endtask

  // Holds the input side off until every outstanding result has been seen.
  // Each item yields exactly one result, so an empty ledger means the block is idle.
  task automatic wait_for_positions();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ledger.set_coef(idx, data);
  endtask

  // Loads all five coefficients while the block is idle. With spare_writes set,
  // the unused register indexes are written too; the block must ignore them.
  task automatic load_coefs(input logic signed [DATA_W-1:0] nb0, nb1, nb2, na1, na2,
                            input bit spare_writes);
    int i;
    write_reg(REG_B0, nb0);
    write_reg(REG_B1, nb1);
    write_reg(REG_B2, nb2);
    write_reg(REG_A1, na1);
    write_reg(REG_A2, na2);
    if (spare_writes) begin
      for (i = int'(REG_A2) + 1; i < (1 << CFG_IDX_W); i++) begin
        write_reg(CFG_IDX_W'(i), $urandom);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly setpoints across the axis range and up to 20 degrees beyond each limit, so
  // both clamps and the free range all get hit; now and then a raw word or a signed extreme.
  function automatic logic signed [DATA_W-1:0] pick_setpoint(input logic [AXIS_W-1:0] ax);
    int row;
    int base;
    int span;
    int roll;
    row  = (ax < JOINTS) ? int'(ax) : 0;
    roll = $urandom_range(0, 9);
    if (roll == 0) return $urandom;
    if (roll == 1) return ($urandom_range(0, 1) != 0) ? S32_TOP : S32_BOTTOM;
    base = ledger.floor_lim[row] - 20 * Q16;
    span = ledger.ceil_lim[row] - ledger.floor_lim[row] + 40 * Q16;
    return base + int'($urandom_range(0, span));
  endfunction

  // Calibration offsets are usually a few degrees; the rest are a raw word or a signed extreme.
  function automatic logic signed [DATA_W-1:0] pick_offset();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return $urandom;
    if (roll == 1) return ($urandom_range(0, 1) != 0) ? S32_TOP : S32_BOTTOM;
    return int'($urandom_range(0, 20 * Q16)) - 10 * Q16;
  endfunction

  // Random traffic: mostly filter steps on valid joints, with occasional
  // re-inits that restart an axis history and out-of-range axis numbers.
  task automatic run_random(input int count);
    int               n;
    int               roll;
    logic [AXIS_W-1:0] ax;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 199) == 0) wait_for_positions();
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        ax = AXIS_W'($urandom_range(0, JOINTS - 1));
        send_item(CMD_INIT, ax, pick_setpoint(ax), $urandom);
      end else if (roll < 14) begin
        ax = AXIS_W'($urandom_range(JOINTS, (1 << AXIS_W) - 1));
        send_item(1'($urandom_range(0, 1)), ax, $urandom, $urandom);
      end else begin
        ax = AXIS_W'($urandom_range(0, JOINTS - 1));
        send_item(CMD_STEP, ax, pick_setpoint(ax), pick_offset());
      end
    end
  endtask

  initial begin
    ledger = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With the reset coefficients every filter output is zero, which still
    // exercises the setpoint clamp; axis 2 tops out at zero degrees.
    send_item(CMD_STEP, 3'd0, 32'sd0, 32'sd0);
    send_item(CMD_STEP, 3'd2, S32_TOP, 32'sd0);
    wait_for_positions();
    load_coefs(LP_B0, LP_B1, LP_B0, LP_A1, LP_A2, 1'b0);

    // Preload histories, some at the signed extremes so that the next step's
    // partial sums go beyond the 32-bit range.
    send_item(CMD_INIT, 3'd0, 32'sd0, S32_TOP);
    send_item(CMD_INIT, 3'd1, 100 * Q16, 32'sd0);
    send_item(CMD_INIT, 3'd2, -50 * Q16, S32_BOTTOM);
    send_item(CMD_INIT, 3'd3, S32_TOP, 32'sd0);
    send_item(CMD_INIT, 3'd4, S32_BOTTOM, 32'sd0);
    send_item(CMD_INIT, 3'd5, 2000 * Q16, 32'sd0);
    // Axis numbers past the last joint return an empty result and touch nothing.
    send_item(CMD_INIT, 3'd6, S32_TOP, S32_TOP);
    send_item(CMD_STEP, 3'd7, S32_BOTTOM, S32_TOP);
    // Setpoint clamps on both sides, then offsets that overflow 32 bits.
    send_item(CMD_STEP, 3'd0, S32_TOP, 32'sd0);
    send_item(CMD_STEP, 3'd1, S32_BOTTOM, 32'sd0);
    send_item(CMD_STEP, 3'd0, 170 * Q16, S32_TOP);
    send_item(CMD_STEP, 3'd1, -85 * Q16, S32_BOTTOM);
    // Partial filter sums beyond the 32-bit range on the saturated histories.
    send_item(CMD_STEP, 3'd3, 32'sd0, 32'sd0);
    send_item(CMD_STEP, 3'd4, 32'sd0, 32'sd0);
    // Exactly at a limit, and one LSB below the other one.
    send_item(CMD_STEP, 3'd5, 2700 * Q16, 32'sd0);
    send_item(CMD_STEP, 3'd5, -2700 * Q16 - 1, 32'sd0);

    run_random(ITEMS_PER_PHASE);

    wait_for_positions();
    load_coefs(S32_TOP, S32_TOP, S32_TOP, S32_TOP, S32_TOP, 1'b0);
    run_random(ITEMS_PER_PHASE);

    wait_for_positions();
    load_coefs(S32_BOTTOM, S32_BOTTOM, S32_BOTTOM, S32_BOTTOM, S32_BOTTOM, 1'b0);
    run_random(ITEMS_PER_PHASE);

    wait_for_positions();
    load_coefs($urandom, $urandom, $urandom, $urandom, $urandom, 1'b1);
    run_random(ITEMS_PER_PHASE);

    // A plain pass-through: the output follows the clamped, offset input.
    wait_for_positions();
    load_coefs(Q30_ONE, Q30_ZERO, Q30_ZERO, Q30_ZERO, Q30_ZERO, 1'b1);
    run_random(ITEMS_PER_PHASE);

    // Last phase: a unity-gain low-pass with no idling on either side.
    wait_for_positions();
    idling = 1'b0;
    load_coefs(Q30_QUARTER, Q30_QUARTER, Q30_ZERO, -2 * Q30_QUARTER, Q30_ZERO, 1'b0);
    run_random(ITEMS_PER_PHASE);

    wait_for_positions();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.errors == 0 && ledger.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
